FILE: hdl/wtrgb_pkg.sv
// ----------------------------------------------------------------------------
// wtrgb_pkg
// Shared types, wavelength breakpoints, reciprocal constants and the gamma
// curve function for the wavelength to rgb colour pipeline.
// ----------------------------------------------------------------------------
package wtrgb_pkg;

  // wavelength breakpoints in tenths of a nanometre
  localparam int unsigned WlW = 14;
  localparam logic [WlW-1:0] Wl380 = 14'd3800;
  localparam logic [WlW-1:0] Wl420 = 14'd4200;
  localparam logic [WlW-1:0] Wl440 = 14'd4400;
  localparam logic [WlW-1:0] Wl490 = 14'd4900;
  localparam logic [WlW-1:0] Wl510 = 14'd5100;
  localparam logic [WlW-1:0] Wl580 = 14'd5800;
  localparam logic [WlW-1:0] Wl645 = 14'd6450;
  localparam logic [WlW-1:0] Wl701 = 14'd7010;
  localparam logic [WlW-1:0] Wl781 = 14'd7810;

  // q0.12 fixed point
  localparam int unsigned QW = 12;
  localparam logic [QW:0] QOne = 13'd4096;

  // constant divider datapath widths
  localparam int unsigned NumW     = 22;
  localparam int unsigned DivW     = 10;
  localparam int unsigned RcpW     = 18;
  localparam int unsigned RcpShift = 24;

  // reciprocals floor(2^24 / d) for every divisor used
  localparam logic [RcpW-1:0] Rcp600 = RcpW'((64'd1 << RcpShift) / 600);
  localparam logic [RcpW-1:0] Rcp500 = RcpW'((64'd1 << RcpShift) / 500);
  localparam logic [RcpW-1:0] Rcp200 = RcpW'((64'd1 << RcpShift) / 200);
  localparam logic [RcpW-1:0] Rcp700 = RcpW'((64'd1 << RcpShift) / 700);
  localparam logic [RcpW-1:0] Rcp650 = RcpW'((64'd1 << RcpShift) / 650);
  localparam logic [RcpW-1:0] Rcp125 = RcpW'((64'd1 << RcpShift) / 125);

  // gamma table geometry
  localparam int unsigned TableTop  = 255;
  localparam int unsigned TableSize = 256;
  localparam int unsigned IdxW      = 8;

  // colour ramp segment
  typedef enum logic [2:0] {
    SEG_NONE,
    SEG_VIOLET,
    SEG_BLUE,
    SEG_CYAN,
    SEG_GREEN,
    SEG_YELLOW,
    SEG_RED
  } seg_e;

  // intensity factor band
  typedef enum logic [1:0] {
    FB_ZERO,
    FB_RISE,
    FB_ONE,
    FB_FALL
  } band_e;

  // stage control for the constant divider
  typedef struct packed {
    logic mul_en;
    logic fix_en;
    logic mul_vld;
  } div_ctl_t;

  // largest y with y^5 * 255^4 <= m^5 * idx^4, m = 2^out_bits - 1
  function automatic logic [QW-1:0] gamma_entry(int unsigned out_bits, int unsigned idx);
    logic [127:0] m;
    logic [127:0] k;
    logic [127:0] i4;
    logic [127:0] rhs;
    logic [127:0] y;
    logic [127:0] lhs;
    logic [QW:0]  lo;
    logic [QW:0]  hi;
    logic [QW:0]  mid;
    m   = (128'd1 << out_bits) - 128'd1;
    k   = 128'(TableTop) * 128'(TableTop) * 128'(TableTop) * 128'(TableTop);
    i4  = 128'(idx) * 128'(idx) * 128'(idx) * 128'(idx);
    rhs = m * m * m * m * m * i4;
    lo  = '0;
    hi  = m[QW:0];
    for (int s = 0; s < 14; s++) begin
      if (lo < hi) begin
        mid = (QW+1)'(((QW+2)'(lo) + (QW+2)'(hi) + (QW+2)'(1)) >> 1);
        y   = 128'(mid);
        lhs = y * y * y * y * y * k;
        if (lhs <= rhs) begin
          lo = mid;
        end else begin
          hi = mid - (QW+1)'(1);
        end
      end
    end
    return lo[QW-1:0];
  endfunction

endpackage

FILE: hdl/wtrgb_const_div.sv
// ----------------------------------------------------------------------------
// wtrgb_const_div
// Two-stage divide by a small constant: reciprocal multiply, then one
// remainder compare and correction step.
// ----------------------------------------------------------------------------
module wtrgb_const_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  wtrgb_pkg::div_ctl_t              ctl_i,
  input  logic [wtrgb_pkg::NumW-1:0]       num_i,
  input  logic [wtrgb_pkg::DivW-1:0]       div_i,
  input  logic [wtrgb_pkg::RcpW-1:0]       rcp_i,
  output logic [wtrgb_pkg::QW:0]           quo_o
);

  localparam int unsigned ProdW = wtrgb_pkg::NumW + wtrgb_pkg::RcpW;

  logic [ProdW-1:0]              prod_c;
  logic [wtrgb_pkg::QW:0]        q0_d, q0_q;
  logic [wtrgb_pkg::NumW-1:0]    num_q;
  logic [wtrgb_pkg::DivW-1:0]    div_q;
  logic [wtrgb_pkg::NumW-1:0]    rem_c;
  logic                          need_c;
  logic [wtrgb_pkg::NumW-1:0]    rem_fix_c;
  logic [wtrgb_pkg::QW:0]        quo_d, quo_q;

  // estimate, at most one below the true quotient; full scale 1.0 needs the top bit
  assign prod_c = ProdW'(num_i) * ProdW'(rcp_i);
  assign q0_d   = prod_c[wtrgb_pkg::RcpShift +: (wtrgb_pkg::QW + 1)];

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      q0_q  <= q0_d;
      num_q <= num_i;
      div_q <= div_i;
    end
  end

  // remainder check and single correction
  assign rem_c     = num_q - wtrgb_pkg::NumW'(q0_q * div_q);
  assign need_c    = rem_c >= wtrgb_pkg::NumW'(div_q);
  assign rem_fix_c = need_c ? rem_c - wtrgb_pkg::NumW'(div_q) : rem_c;
  assign quo_d     = q0_q + (wtrgb_pkg::QW + 1)'(need_c);

  always_ff @(posedge clk_i) begin
    if (ctl_i.fix_en) begin
      quo_q <= quo_d;
    end
  end

  assign quo_o = quo_q;

  // one correction step must always be enough
  a_one_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.mul_vld |-> rem_fix_c < wtrgb_pkg::NumW'(div_q))
    else $error("constant divider remainder out of range");

endmodule

FILE: hdl/wavelength_to_rgb_colour.sv
// ----------------------------------------------------------------------------
// wavelength_to_rgb_colour
// Maps a wavelength in tenths of a nanometre to gamma-corrected red, green
// and blue levels through a six-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries wavelength_tenth_nm_i; output
//   channel out_valid_o/out_ready_i carries red/green/blue_level_o, each
//   OUT_BITS wide. A transaction completes when valid and ready are both high.
//   Throughput is one transaction per cycle while the receiver keeps
//   out_ready_i high, through the six register stages: segment and band
//   decode, reciprocal multiply, remainder correction, ramp times factor,
//   gamma index, gamma table read.
//   Each stage holds its own valid bit and advances whenever the stage after
//   it is empty or moving, so bubbles close up under a stall. When the
//   receiver holds out_ready_i low, results pile up stage by stage and
//   in_ready_o drops only once all six stages are full; nothing is lost.
//   Reset empties the pipeline: out_valid_o is low and in_ready_o high right
//   after reset. Wavelengths below 380 nm or from 781 nm up give black.
// ----------------------------------------------------------------------------
module wavelength_to_rgb_colour #(
  parameter int unsigned OUT_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [13:0]          wavelength_tenth_nm_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OUT_BITS-1:0]  red_level_o,
  output logic [OUT_BITS-1:0]  green_level_o,
  output logic [OUT_BITS-1:0]  blue_level_o
);

  localparam int unsigned NumStages = 6;
  localparam int unsigned QW        = wtrgb_pkg::QW;
  localparam int unsigned PW        = QW + 1;
  localparam int unsigned SumW      = PW + 8;

  // pipeline valid and ready
  logic [NumStages-1:0] vld_d, vld_q;
  logic [NumStages-1:0] rdy;

  always_comb begin
    rdy[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (rdy[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (rdy[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NumStages-1];

  // stage 0: segment decode and divider operands
  logic [13:0]                     wl_c;
  wtrgb_pkg::seg_e                 seg_c;
  logic [wtrgb_pkg::DivW-1:0]      dist_c;
  logic [wtrgb_pkg::DivW-1:0]      divr_c;
  logic [wtrgb_pkg::RcpW-1:0]      rcpr_c;

  assign wl_c = wavelength_tenth_nm_i;

  always_comb begin
    seg_c  = wtrgb_pkg::SEG_NONE;
    dist_c = '0;
    divr_c = 10'd600;
    rcpr_c = wtrgb_pkg::Rcp600;
    priority if (wl_c < wtrgb_pkg::Wl380) begin
      seg_c = wtrgb_pkg::SEG_NONE;
    end else if (wl_c < wtrgb_pkg::Wl440) begin
      seg_c  = wtrgb_pkg::SEG_VIOLET;
      dist_c = wtrgb_pkg::DivW'(wtrgb_pkg::Wl440 - wl_c);
      divr_c = 10'd600;
      rcpr_c = wtrgb_pkg::Rcp600;
    end else if (wl_c < wtrgb_pkg::Wl490) begin
      seg_c  = wtrgb_pkg::SEG_BLUE;
      dist_c = wtrgb_pkg::DivW'(wl_c - wtrgb_pkg::Wl440);
      divr_c = 10'd500;
      rcpr_c = wtrgb_pkg::Rcp500;
    end else if (wl_c < wtrgb_pkg::Wl510) begin
      seg_c  = wtrgb_pkg::SEG_CYAN;
      dist_c = wtrgb_pkg::DivW'(wtrgb_pkg::Wl510 - wl_c);
      divr_c = 10'd200;
      rcpr_c = wtrgb_pkg::Rcp200;
    end else if (wl_c < wtrgb_pkg::Wl580) begin
      seg_c  = wtrgb_pkg::SEG_GREEN;
      dist_c = wtrgb_pkg::DivW'(wl_c - wtrgb_pkg::Wl510);
      divr_c = 10'd700;
      rcpr_c = wtrgb_pkg::Rcp700;
    end else if (wl_c < wtrgb_pkg::Wl645) begin
      seg_c  = wtrgb_pkg::SEG_YELLOW;
      dist_c = wtrgb_pkg::DivW'(wtrgb_pkg::Wl645 - wl_c);
      divr_c = 10'd650;
      rcpr_c = wtrgb_pkg::Rcp650;
    end else if (wl_c < wtrgb_pkg::Wl781) begin
      seg_c = wtrgb_pkg::SEG_RED;
    end else begin
      seg_c = wtrgb_pkg::SEG_NONE;
    end
  end

  // stage 0: intensity band and factor numerator, scaled so the divisor is 125
  wtrgb_pkg::band_e                band_c;
  logic [8:0]                      rise_off_c;
  logic [11:0]                     x_rise_c;
  logic [12:0]                     x_fall_c;
  logic [wtrgb_pkg::NumW-1:0]      numf_c;

  assign rise_off_c = 9'(wl_c - wtrgb_pkg::Wl380);
  assign x_rise_c   = 12'(12'd1200 + 12'(rise_off_c) * 12'd7);
  assign x_fall_c   = 13'(17'd57000 - 17'(wl_c) * 17'd7);

  always_comb begin
    band_c = wtrgb_pkg::FB_ZERO;
    numf_c = '0;
    priority if (wl_c < wtrgb_pkg::Wl380) begin
      band_c = wtrgb_pkg::FB_ZERO;
    end else if (wl_c < wtrgb_pkg::Wl420) begin
      band_c = wtrgb_pkg::FB_RISE;
      numf_c = {3'b000, x_rise_c, 7'b0000000};
    end else if (wl_c < wtrgb_pkg::Wl701) begin
      band_c = wtrgb_pkg::FB_ONE;
    end else if (wl_c < wtrgb_pkg::Wl781) begin
      band_c = wtrgb_pkg::FB_FALL;
      numf_c = {3'b000, x_fall_c, 6'b000000};
    end else begin
      band_c = wtrgb_pkg::FB_ZERO;
    end
  end

  wtrgb_pkg::seg_e                 seg0_q, seg1_q, seg2_q;
  wtrgb_pkg::band_e                band0_q, band1_q, band2_q;
  logic [wtrgb_pkg::NumW-1:0]      numr0_q, numf0_q;
  logic [wtrgb_pkg::DivW-1:0]      divr0_q;
  logic [wtrgb_pkg::RcpW-1:0]      rcpr0_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      seg0_q  <= seg_c;
      band0_q <= band_c;
      numr0_q <= {dist_c, 12'b0};
      divr0_q <= divr_c;
      rcpr0_q <= rcpr_c;
      numf0_q <= numf_c;
    end
  end

  // stages 1 and 2: constant dividers for ramp and factor
  wtrgb_pkg::div_ctl_t  div_ctl;
  logic [PW-1:0]        ramp_q;
  logic [PW-1:0]        fac_q;

  assign div_ctl.mul_en  = rdy[1];
  assign div_ctl.fix_en  = rdy[2];
  assign div_ctl.mul_vld = vld_q[1];

  wtrgb_const_div u_ramp_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .num_i  (numr0_q),
    .div_i  (divr0_q),
    .rcp_i  (rcpr0_q),
    .quo_o  (ramp_q)
  );

  wtrgb_const_div u_fac_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .num_i  (numf0_q),
    .div_i  (10'd125),
    .rcp_i  (wtrgb_pkg::Rcp125),
    .quo_o  (fac_q)
  );

  // segment and band ride alongside the dividers
  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      seg1_q  <= seg0_q;
      band1_q <= band0_q;
    end
    if (rdy[2]) begin
      seg2_q  <= seg1_q;
      band2_q <= band1_q;
    end
  end

  // stage 3: base colour times intensity factor
  logic [PW-1:0]   ramp_c, r_c, g_c, b_c, f_c;
  logic [2*PW-1:0] pr_c, pg_c, pb_c;
  logic [PW-1:0]   p_r_q, p_g_q, p_b_q;

  assign ramp_c = ramp_q;

  always_comb begin
    r_c = '0;
    g_c = '0;
    b_c = '0;
    unique case (seg2_q)
      wtrgb_pkg::SEG_VIOLET: begin r_c = ramp_c;          b_c = wtrgb_pkg::QOne; end
      wtrgb_pkg::SEG_BLUE:   begin g_c = ramp_c;          b_c = wtrgb_pkg::QOne; end
      wtrgb_pkg::SEG_CYAN:   begin g_c = wtrgb_pkg::QOne; b_c = ramp_c;          end
      wtrgb_pkg::SEG_GREEN:  begin r_c = ramp_c;          g_c = wtrgb_pkg::QOne; end
      wtrgb_pkg::SEG_YELLOW: begin r_c = wtrgb_pkg::QOne; g_c = ramp_c;          end
      wtrgb_pkg::SEG_RED:    begin r_c = wtrgb_pkg::QOne;                        end
      default:               begin r_c = '0;                                     end
    endcase
  end

  always_comb begin
    unique case (band2_q)
      wtrgb_pkg::FB_RISE,
      wtrgb_pkg::FB_FALL: f_c = fac_q;
      wtrgb_pkg::FB_ONE:  f_c = wtrgb_pkg::QOne;
      default:            f_c = '0;
    endcase
  end

  assign pr_c = r_c * f_c;
  assign pg_c = g_c * f_c;
  assign pb_c = b_c * f_c;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      p_r_q <= pr_c[QW +: PW];
      p_g_q <= pg_c[QW +: PW];
      p_b_q <= pb_c[QW +: PW];
    end
  end

  // stage 4: rounded gamma table index, p * 255 / 4096
  logic [SumW-1:0]            sr_c, sg_c, sb_c;
  logic [wtrgb_pkg::IdxW-1:0] idx_r_q, idx_g_q, idx_b_q;

  assign sr_c = {p_r_q, 8'b0} - SumW'(p_r_q) + SumW'(2048);
  assign sg_c = {p_g_q, 8'b0} - SumW'(p_g_q) + SumW'(2048);
  assign sb_c = {p_b_q, 8'b0} - SumW'(p_b_q) + SumW'(2048);

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      idx_r_q <= sr_c[QW +: wtrgb_pkg::IdxW];
      idx_g_q <= sg_c[QW +: wtrgb_pkg::IdxW];
      idx_b_q <= sb_c[QW +: wtrgb_pkg::IdxW];
    end
  end

  // stage 5: gamma table read into the output register
  logic [OUT_BITS-1:0] gamma_lut [wtrgb_pkg::TableSize];

  for (genvar gi = 0; gi < wtrgb_pkg::TableSize; gi++) begin : g_lut
    assign gamma_lut[gi] = OUT_BITS'(wtrgb_pkg::gamma_entry(OUT_BITS, gi));
  end

  logic [OUT_BITS-1:0] red_q, green_q, blue_q;

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      red_q   <= gamma_lut[idx_r_q];
      green_q <= gamma_lut[idx_g_q];
      blue_q  <= gamma_lut[idx_b_q];
    end
  end

  assign red_level_o   = red_q;
  assign green_level_o = green_q;
  assign blue_level_o  = blue_q;

  // input back-pressure only once every stage holds a transaction
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> &vld_q)
    else $error("input stalled with an empty pipeline stage");

  // zero intensity band gives black products
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdy[3] && vld_q[2] && band2_q == wtrgb_pkg::FB_ZERO
    |=> p_r_q == '0 && p_g_q == '0 && p_b_q == '0)
    else $error("nonzero colour outside the visible band");

  // factor ramps stay between roughly 0.29 and 1.0
  a_fac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] && (band2_q == wtrgb_pkg::FB_RISE || band2_q == wtrgb_pkg::FB_FALL)
    |-> fac_q >= 13'd1196 && fac_q <= 13'd4088)
    else $error("intensity factor out of range");

endmodule
